>>> src/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants for the key/value table
// request modes, result status codes, sequencer states and defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kvt_pkg;
    localparam int DEPTH_DEF      = 128;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_UPDATE = 3'd1,
        MODE_LOOKUP = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SCHK,
        S_SHIFT,
        S_SWR,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

>>> src/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram: generic single-port synchronous ram
// one write or one read a cycle, read data registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else
            rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table: fixed-capacity key/value table with linear key search
// entries kept in insertion order; delete compacts later entries down
// ----------------------------------------------------------------------------
// clear and unused modes go straight to the done state; a search walks the key
//   ram slot by slot, a read state then a compare state for each slot
// delete then moves each later slot down: a read, then a write of both rams
// one request at a time; a new one is accepted only after the last result is taken
// reset clears the entry count and sequencer; ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module key_value_table
    import kvt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // mode[2:0], req_key[34:3], req_value[66:35]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // status[1:0], hit[2], read_value[34:3],
                                        // entry_total[42:35]
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;
    logic [2:0]            mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [1:0]            ost_reg;
    logic                  ohit_reg;
    logic [31:0]           ord_reg;
    logic                  ovalid_reg;

    logic                  k_we, v_we;
    logic [AW-1:0]         addr;
    logic [KEY_BITS-1:0]   k_wd, k_rd;
    logic [VALUE_BITS-1:0] v_wd, v_rd;

    kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key (
        .clk(clk), .we(k_we), .addr(addr), .wdata(k_wd), .rdata(k_rd));
    kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val (
        .clk(clk), .we(v_we), .addr(addr), .wdata(v_wd), .rdata(v_rd));

    logic s_acc, found, in_range, last_move;
    assign s_tready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign in_range  = idx_reg < cnt_reg;
    assign found     = (k_rd == key_reg);
    assign last_move = (idx_reg + CW'(1)) >= cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_acc)
                    state_next = (s_tdata[2:0] <= MODE_DELETE) ? S_SRCH : S_DONE;
            S_SRCH:  state_next = in_range ? S_SCHK : S_DONE;
            S_SCHK:
                if (found)
                    state_next = (mode_reg == MODE_DELETE) ? S_SHIFT : S_DONE;
                else
                    state_next = S_SRCH;
            S_SHIFT: state_next = last_move ? S_DONE : S_SWR;
            S_SWR:   state_next = S_SHIFT;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ram control and index
    always_comb
    begin
        k_we     = 1'b0;
        v_we     = 1'b0;
        addr     = idx_reg[AW-1:0];
        k_wd     = key_reg;
        v_wd     = val_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            S_IDLE:  idx_next = '0;
            S_SRCH:
                if (!in_range && mode_reg == MODE_INSERT && cnt_reg < CW'(DEPTH))
                begin
                    k_we = 1'b1;
                    v_we = 1'b1;
                end
            S_SCHK:
                if (found)
                begin
                    if (mode_reg == MODE_INSERT || mode_reg == MODE_UPDATE)
                        v_we = 1'b1;
                end
                else
                    idx_next = idx_reg + CW'(1);
            S_SHIFT:
                // read the next slot for the move down
                if (!last_move)
                    addr = AW'(idx_reg + CW'(1));
            S_SWR:
            begin
                k_we     = 1'b1;
                v_we     = 1'b1;
                k_wd     = k_rd;
                v_wd     = v_rd;
                idx_next = idx_reg + CW'(1);
            end
            S_DONE:  ;
            default: ;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == S_IDLE && s_acc && s_tdata[2:0] == MODE_CLEAR)
            cnt_next = '0;
        else if (state_reg == S_SRCH && !in_range && mode_reg == MODE_INSERT
                 && cnt_reg < CW'(DEPTH))
            cnt_next = cnt_reg + CW'(1);
        else if (state_reg == S_SHIFT && last_move)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (state_reg == S_DONE)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    // request and result words
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            mode_reg <= s_tdata[2:0];
            key_reg  <= KEY_BITS'(s_tdata[34:3]);
            val_reg  <= VALUE_BITS'(s_tdata[66:35]);
            ost_reg  <= ST_OK;
            ohit_reg <= 1'b0;
            ord_reg  <= '0;
        end
        else if (state_reg == S_SRCH && !in_range)
        begin
            if (mode_reg == MODE_INSERT)
                ost_reg <= (cnt_reg < CW'(DEPTH)) ? ST_OK : ST_FULL;
            else
                ost_reg <= ST_NOTFOUND;
        end
        else if (state_reg == S_SCHK && found)
        begin
            ohit_reg <= 1'b1;
            if (mode_reg == MODE_LOOKUP)
                ord_reg <= 32'(v_rd);
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, 8'(cnt_reg), ord_reg, ohit_reg, ost_reg};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("count exceeds depth");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !k_we && !v_we)
        else $error("ram write while idle");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_DONE)
        else $error("result without finish");
endmodule
`default_nettype wire
